>>> sv/per_source_rate_alarm_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-source rate alarm
// Shared concurrent-check templates: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_RATE_ALARM_DEFINES_SVH
`define PER_SOURCE_RATE_ALARM_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PRSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PRSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/prsa_pkg.sv
// ----------------------------------------------------------------------------
// prsa_pkg
// Types and constants shared by the per-source rate alarm and its cells.
// ----------------------------------------------------------------------------
package prsa_pkg;

  localparam int ENTRIES_DEF = 32;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [15:0] THRESH_RST = 16'd10;
  localparam logic [15:0] WINDOW_RST = 16'd2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS  = 1'b1;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    logic        alert;
    logic [4:0]  entry_index;
    logic        table_full;
    logic [15:0] packet_count;
  } out_word_t;

  // Lookup token that walks the cell row
  typedef struct packed {
    logic      valid;
    logic      done;
    in_word_t  req;
    out_word_t res;
  } tok_t;

endpackage

>>> sv/per_source_rate_alarm.sv
// ----------------------------------------------------------------------------
// per_source_rate_alarm
// Fixed-window packet-rate detector keyed by IPv4 source address.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one word per packet: source
//   address and current seconds count. Output channel out_valid/out_stall
//   returns one word per packet: alert, entry index, table-full flag and the
//   entry count after the packet.
//   The table is a row of ENTRIES cells; a lookup word steps one cell per
//   cycle through the cell registers and then into the output register, and
//   a new word is taken only after the previous one has left the cell row.
//   Only one word walks the row at a time; in_stall is high during the walk.
//   A finished word waits in the output register, and a second one in a skid
//   register, so a stalled receiver holds at most two results; in_stall stays
//   high while the skid is occupied.
//   Reset empties the table, clears both channels and loads threshold 10 and
//   window 2 s. Write cfg_* only while no word is in flight.
// ----------------------------------------------------------------------------
module per_source_rate_alarm #(
  parameter int ENTRIES = prsa_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  prsa_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output prsa_pkg::out_word_t            out_word,
  input  logic                           cfg_we,
  input  logic [prsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prsa_pkg::CFG_W-1:0]     cfg_data
);
  import prsa_pkg::*;

  logic [15:0] thresh_r, window_r;
  logic        in_flight_r;
  logic        out_valid_r, skid_valid_r;
  out_word_t   out_r, skid_r;

  tok_t        tok [ENTRIES+1];
  tok_t        exit_tok;
  out_word_t   exit_res;
  logic        in_acc, pop;

  assign in_acc = in_valid && !in_stall;
  assign pop    = out_valid_r && !out_stall;

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = in_acc;
    tok[0].req   = in_word;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    prsa_cell #(.CELL_IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .thresh  (thresh_r),
      .window  (window_r),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  assign exit_tok = tok[ENTRIES];

  // No cell took the word: table is full
  always_comb begin
    exit_res = exit_tok.res;
    if (!exit_tok.done) begin
      exit_res            = '0;
      exit_res.table_full = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r     <= THRESH_RST;
      window_r     <= WINDOW_RST;
      in_flight_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ALERT_THRESHOLD: thresh_r <= cfg_data;
          REG_WINDOW_SECONDS:  window_r <= cfg_data;
          default:             ;
        endcase
      end
      if (in_acc) begin
        in_flight_r <= 1'b1;
      end else if (exit_tok.valid) begin
        in_flight_r <= 1'b0;
      end
      if (pop) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end else if (exit_tok.valid) begin
          out_r <= exit_res;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (exit_tok.valid) begin
        if (out_valid_r) begin
          // receiver holds: park the word in the skid
          skid_r       <= exit_res;
          skid_valid_r <= 1'b1;
        end else begin
          out_r       <= exit_res;
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  assign in_stall  = in_flight_r || skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

>>> sv/prsa_cell.sv
// ----------------------------------------------------------------------------
// prsa_cell
// One table entry: key, count and window start; serves or passes the token.
// ----------------------------------------------------------------------------
module prsa_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [15:0]      thresh,
  input  logic [15:0]      window,
  input  prsa_pkg::tok_t   tok_in,
  output prsa_pkg::tok_t   tok_out
);
  import prsa_pkg::*;

  logic        valid_r, valid_nxt;
  logic [31:0] key_r, key_nxt;
  logic [15:0] count_r, count_nxt;
  logic [31:0] start_r, start_nxt;
  tok_t        tok_r, tok_nxt;

  logic [15:0] cnt_inc;
  logic [31:0] elapsed;
  logic        live;

  assign live    = tok_in.valid && !tok_in.done;
  assign cnt_inc = (count_r == COUNT_MAX) ? count_r : count_r + 16'd1;
  assign elapsed = tok_in.req.now_seconds - start_r;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    count_nxt = count_r;
    start_nxt = start_r;
    tok_nxt   = tok_in;
    if (live) begin
      if (valid_r && (key_r == tok_in.req.src_ip)) begin
        tok_nxt.done                 = 1'b1;
        tok_nxt.res.entry_index      = 5'(CELL_IDX);
        tok_nxt.res.table_full       = 1'b0;
        if (elapsed < {16'd0, window}) begin
          count_nxt                  = cnt_inc;
          tok_nxt.res.alert          = (cnt_inc > thresh);
          tok_nxt.res.packet_count   = cnt_inc;
        end else begin
          // window ran out: restart it
          count_nxt                  = '0;
          start_nxt                  = tok_in.req.now_seconds;
          tok_nxt.res.alert          = 1'b0;
          tok_nxt.res.packet_count   = '0;
        end
      end else if (!valid_r) begin
        // first free entry: claim it for the new source
        valid_nxt                    = 1'b1;
        key_nxt                      = tok_in.req.src_ip;
        count_nxt                    = 16'd1;
        start_nxt                    = tok_in.req.now_seconds;
        tok_nxt.done                 = 1'b1;
        tok_nxt.res.alert            = 1'b0;
        tok_nxt.res.entry_index      = 5'(CELL_IDX);
        tok_nxt.res.table_full       = 1'b0;
        tok_nxt.res.packet_count     = 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    count_r <= count_nxt;
    start_r <= start_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> sv/prsa_checker.sv
// ----------------------------------------------------------------------------
// prsa_checker
// Port-level checks for the per-source rate alarm, bound to the top level.
// ----------------------------------------------------------------------------
`include "per_source_rate_alarm_defines.svh"

module prsa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input prsa_pkg::in_word_t             in_word,
  input logic                           out_valid,
  input logic                           out_stall,
  input prsa_pkg::out_word_t            out_word,
  input logic                           cfg_we,
  input logic [prsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [prsa_pkg::CFG_W-1:0]     cfg_data
);
  import prsa_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_word, cfg_we, cfg_index, cfg_data};

  `PRSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_word), "stalled output word changed")

  `PRSA_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall,
    in_stall, "second word taken while a lookup walks the table")

  `PRSA_ASSERT_SAME(a_full_clean, out_valid && out_word.table_full,
    !out_word.alert && (out_word.packet_count == 16'd0) &&
    (out_word.entry_index == 5'd0), "table-full word carries entry data")

  // an alert needs a count above the threshold, so the count is never zero
  `PRSA_ASSERT_SAME(a_alert_count, out_valid && out_word.alert,
    !out_word.table_full && (out_word.packet_count != 16'd0),
    "alert without a counted repeat source")

endmodule

bind per_source_rate_alarm prsa_checker u_prsa_checker (.*);

>>> tb/sv/per_source_rate_alarm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_rate_alarm_tb
// Drives packet words through the rate alarm under random idling on both
// channels, predicts every result word from a local copy of the source table
// and checks the returned words in order against those predictions.
// ----------------------------------------------------------------------------
module per_source_rate_alarm_tb;
  import prsa_pkg::*;

  localparam int TABLE_DEPTH   = ENTRIES_DEF;
  localparam int POOL_SIZE     = 40;
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int MAX_REPORTS   = 10;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ALERT_THRESHOLD;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Local copy of the source table and limits
  logic [31:0] key_tab   [TABLE_DEPTH];
  logic [15:0] count_tab [TABLE_DEPTH];
  logic [31:0] start_tab [TABLE_DEPTH];
  int          used_entries;
  logic [15:0] cur_threshold;
  logic [15:0] cur_window;

  out_word_t   verdict_q[$];
  logic [31:0] src_pool [POOL_SIZE];
  logic [31:0] clock_now;
  int          fail_count;
  int          idle_pct;
  int          hold_req;
  int          cycle_count;

  per_source_rate_alarm u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("per_source_rate_alarm verification failed");
    $finish;
  end

  // Look up the source, update its entry and return the word the block owes.
  function automatic out_word_t score_packet(in_word_t pkt);
    out_word_t   res;
    int          hit;
    logic [31:0] elapsed;
    logic [15:0] cnt;
    res = '0;
    hit = -1;
    for (int i = 0; i < used_entries; i++) begin
      if (hit < 0 && key_tab[i] == pkt.src_ip) hit = i;
    end
    if (hit < 0) begin
      if (used_entries >= TABLE_DEPTH) begin
        res.table_full = 1'b1;
      end else begin
        key_tab[used_entries]   = pkt.src_ip;
        start_tab[used_entries] = pkt.now_seconds;
        count_tab[used_entries] = 16'd1;
        res.entry_index         = 5'(used_entries);
        res.packet_count        = 16'd1;
        used_entries++;
      end
    end else begin
      cnt     = count_tab[hit];
      elapsed = pkt.now_seconds - start_tab[hit];
      if (cnt != COUNT_MAX) cnt++;
      if (elapsed < {16'h0, cur_window}) begin
        res.alert = (cnt > cur_threshold);
      end else begin
        // window ran out: restart it at this packet
        start_tab[hit] = pkt.now_seconds;
        cnt            = '0;
      end
      count_tab[hit]   = cnt;
      res.entry_index  = 5'(hit);
      res.packet_count = cnt;
    end
    return res;
  endfunction

  function automatic bit is_known(logic [31:0] ip);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < used_entries; i++) begin
      if (key_tab[i] == ip) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic note_failure(string what, out_word_t exp_w, out_word_t got_w);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t %s: expected alert=%0b idx=%0d full=%0b count=%0d, got alert=%0b idx=%0d full=%0b count=%0d",
               $realtime, what, exp_w.alert, exp_w.entry_index, exp_w.table_full,
               exp_w.packet_count, got_w.alert, got_w.entry_index, got_w.table_full,
               got_w.packet_count);
    end
  endtask

  task automatic check_result(out_word_t got_w);
    out_word_t exp_w;
    if (verdict_q.size() == 0) begin
      note_failure("word with nothing expected", '0, got_w);
    end else begin
      exp_w = verdict_q.pop_front();
      if (got_w.alert !== exp_w.alert || got_w.entry_index !== exp_w.entry_index ||
          got_w.table_full !== exp_w.table_full ||
          got_w.packet_count !== exp_w.packet_count) begin
        note_failure("result mismatch", exp_w, got_w);
      end
    end
  endtask

  // Result side: check accepted words, stall in short bursts or on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_result(out_word);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        stall_left = $urandom_range(1, 4);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one packet word and hold it until the block takes it.
  task automatic send_packet(logic [31:0] ip, logic [31:0] now);
    in_word_t w;
    w.src_ip      = ip;
    w.now_seconds = now;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    verdict_q.push_back(score_packet(w));
  endtask

  // Stop offering and wait until every result word is back.
  task automatic settle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_limits(logic [15:0] threshold, logic [15:0] window);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ALERT_THRESHOLD;
    cfg_data  <= threshold;
    @(posedge clk);
    cur_threshold = threshold;
    cfg_index <= REG_WINDOW_SECONDS;
    cfg_data  <= window;
    @(posedge clk);
    cur_window = window;
    cfg_we <= 1'b0;
  endtask

  // Mostly a few busy sources, some spread over the pool, a few never seen.
  function automatic logic [31:0] pick_source();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return src_pool[$urandom_range(0, 3)];
    if (r < 90) return src_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [31:0] advance_clock(logic [31:0] now);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return now;
    if (r < 85) return now + 32'd1;
    if (r < 95) return now + 32'($urandom_range(2, 8));
    return $urandom;
  endfunction

  task automatic run_random_phase(int items, logic [15:0] threshold, logic [15:0] window,
                                  int idle);
    settle();
    apply_limits(threshold, window);
    idle_pct = idle;
    repeat (items) begin
      clock_now = advance_clock(clock_now);
      send_packet(pick_source(), clock_now);
    end
  endtask

  // Reset limits: new sources, counting inside the window, wrap of the
  // seconds count and window expiry.
  task automatic test_reset_defaults();
    idle_pct = 25;
    send_packet(32'h0000_0000, 32'h0000_0000);
    send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_packet(32'h0000_0000, 32'h0000_0001);
    send_packet(32'hFFFF_FFFF, 32'h0000_0000);
    send_packet(32'h0000_0000, 32'h0000_0002);
    send_packet(32'hA5A5_5A5A, 32'h8000_0000);
    send_packet(32'hA5A5_5A5A, 32'h8000_0001);
  endtask

  task automatic test_limit_extremes();
    settle();
    apply_limits(16'h0000, 16'hFFFF);
    send_packet(32'h0000_0000, 32'd3);
    send_packet(32'h0000_0000, 32'd65536);
    send_packet(32'h0000_0000, 32'd65537);
    send_packet(32'h0000_0000, 32'd65538);
    settle();
    // zero window: every known source restarts on each packet
    apply_limits(16'hFFFF, 16'h0000);
    send_packet(32'h0000_0000, 32'd65538);
    send_packet(32'hFFFF_FFFF, 32'd65538);
    send_packet(32'h5A5A_A5A5, 32'd7);
    send_packet(32'h5A5A_A5A5, 32'd7);
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < POOL_SIZE; i++) src_pool[i] = $urandom;
    clock_now = $urandom;
    run_random_phase(100, 16'd3, 16'd8, 25);
    run_random_phase(100, 16'd0, 16'hFFFF, 40);
    clock_now = 32'hFFFF_FFF0;
    run_random_phase(100, 16'hFFFF, 16'd1, 0);
    run_random_phase(100, 16'd2, 16'd0, 25);
    run_random_phase(100, 16'd1, 16'd3, 40);
    run_random_phase(100, 16'($urandom_range(0, 6)), 16'($urandom_range(1, 6)), 25);
  endtask

  // Fill every entry, then offer new sources that cannot be stored, then one from the last stored source.
  task automatic test_table_full();
    logic [31:0] ip;
    settle();
    apply_limits(16'd4, 16'd5);
    idle_pct = 25;
    while (used_entries < TABLE_DEPTH || verdict_q.size() == 0) begin
      do ip = $urandom; while (is_known(ip));
      send_packet(ip, clock_now);
    end
    repeat (3) begin
      do ip = $urandom; while (is_known(ip));
      send_packet(ip, clock_now);
    end
    send_packet(key_tab[TABLE_DEPTH - 1], clock_now);
  endtask

  // Hold the result side off long enough that the block backs up its input.
  task automatic test_output_backpressure();
    settle();
    idle_pct = 0;
    hold_req = 400;
    repeat (24) begin
      clock_now = advance_clock(clock_now);
      send_packet(pick_source(), clock_now);
    end
  endtask

  task automatic test_quiet_tail();
    run_random_phase(100, 16'd4, 16'd5, 0);
  endtask

  initial begin
    fail_count    = 0;
    idle_pct      = 0;
    hold_req      = 0;
    used_entries  = 0;
    cur_threshold = THRESH_RST;
    cur_window    = WINDOW_RST;
    clock_now     = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      key_tab[i]   = '0;
      count_tab[i] = '0;
      start_tab[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_limit_extremes();
    test_random_traffic();
    test_table_full();
    test_output_backpressure();
    test_quiet_tail();
    settle();

    if (verdict_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("per_source_rate_alarm verification clean");
    end else begin
      $display("per_source_rate_alarm verification failed");
    end
    $finish;
  end

endmodule
